### hw/rtl/linear_probe_inode_map_macros.svh
// Assertion macros used by the inode map back stage.
`ifndef LINEAR_PROBE_INODE_MAP_MACROS_SVH
`define LINEAR_PROBE_INODE_MAP_MACROS_SVH

// Check a consequence in the same cycle.
`define LPIM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the next cycle.
`define LPIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/lpim_pkg.sv
`default_nettype none

package lpim_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int QDEPTH       = 2;
  localparam int MIX_SHIFT    = 33;
  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

  typedef enum logic [1:0] {
    FN_PUT   = 2'd0,
    FN_REDIR = 2'd1,
    FN_GET   = 2'd2,
    FN_FIND  = 2'd3
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [63:0] ino;
    logic        path_present;
    logic [31:0] path_value;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [31:0] path_out;
    logic [63:0] ino_out;
  } out_word_t;

  // Classified operation handed from front to back.
  typedef struct packed {
    func_t       func;
    logic        skip;
    logic [63:0] ino;
    logic [31:0] value;
  } job_t;

  typedef struct packed {
    logic        used;
    logic [63:0] key;
    logic [31:0] rpath;
    logic [31:0] dpath;
  } entry_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_SUM,
    F_REM,
    F_RED,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLR,
    B_IDLE,
    B_RD,
    B_CHK,
    B_DONE
  } back_state_t;

endpackage

`default_nettype wire

### hw/rtl/linear_probe_inode_map.sv
// Inode map: an open-addressing hash table of CAPACITY slots keyed by a 64-bit
// inode number, with linear probing and wraparound. Each word in gives exactly
// one word out: put real path, set redirect, get path (redirect if nonzero,
// else real) or find the first used slot by path handle. A front stage takes
// a word, runs the two-round mix hash (each 64-bit multiply as three 32x32
// partial products; each round is a multiply state then a sum state, and a
// push state hands the job on once the queue has room) and, when CAPACITY is
// not a power of two, a remainder (eight steps add the residues of the hash
// bits one byte at a time, six compare-and-subtract steps trim the sum below
// CAPACITY); trivial operations and finds skip the hash. A two-entry queue
// decouples it from the back stage, which walks the slot memory one slot at a
// time (registered read, then compare and write). A probe also takes the job
// from the queue and loads the output word, which waits while a stalled word
// is still pending; a find scans from slot 0 and may visit all CAPACITY slots.
// Input is taken one word at a time while the front is idle. After reset the
// back stage clears every slot of the table, and in_stall stays high until
// that pass ends.
`default_nettype none

module linear_probe_inode_map import lpim_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int QW = IW + $bits(job_t);

  logic          front_busy, clearing, take;
  logic          push, q_full, q_valid, pop;
  logic [QW-1:0] push_data, q_data;

  // Hold input off while the front stage is busy or while the table is being cleared.
  assign in_stall = front_busy || clearing;
  assign take     = in_valid && !in_stall;

  lpim_front #(.CAPACITY(CAPACITY)) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_word   (in_word),
    .busy      (front_busy),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  lpim_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop)
  );

  lpim_back #(.CAPACITY(CAPACITY)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_stall (out_stall)
  );

endmodule

`default_nettype wire

### hw/rtl/lpim_front.sv
`default_nettype none

module lpim_front import lpim_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      take,
  input  wire in_word_t                  in_word,
  output logic                           busy,
  output logic                           push,
  output logic [IW+$bits(job_t)-1:0]     push_data,
  input  wire logic                      q_full
);

  localparam bit POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam int SW   = IW + 6;

  // Residue of 2**j modulo CAPACITY for every bit position of the hash.
  function automatic logic [63:0][IW-1:0] rmod_table();
    logic [63:0][IW-1:0] t;
    int r;
    r = 1 % CAPACITY;
    for (int j = 0; j < 64; j++) begin
      t[j] = IW'(r);
      r = (2 * r) % CAPACITY;
    end
    return t;
  endfunction

  localparam logic [63:0][IW-1:0] RMOD = rmod_table();
  localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);

  front_state_t state, state_next;
  job_t         job;
  logic [63:0]  x;
  logic [63:0]  p_ll;
  logic [31:0]  p_lh, p_hl;
  logic         round;
  logic [SW-1:0] acc;
  logic [2:0]   step;

  logic [63:0]  mul_c;
  logic [63:0]  y;
  logic [SW-1:0] part, cap_sh, acc_red;
  logic [IW-1:0] home;
  logic         skip_in;

  assign mul_c   = round ? MIX_C2 : MIX_C1;
  assign y       = p_ll + {p_lh + p_hl, 32'b0};
  assign cap_sh  = CAP_S << step;
  assign acc_red = (acc >= cap_sh) ? acc - cap_sh : acc;
  assign home    = POW2 ? x[IW-1:0] : acc[IW-1:0];

  // Add the residues of the set bits in the low byte of x.
  always_comb begin
    part = '0;
    for (int b = 0; b < 8; b++) begin
      if (x[b]) part = part + SW'(RMOD[{step, 3'(b)}]);
    end
  end

  always_comb begin
    unique case (in_word.func)
      FN_FIND: skip_in = !in_word.path_present;
      FN_GET:  skip_in = in_word.ino == 64'd0;
      default: skip_in = (in_word.ino == 64'd0) || !in_word.path_present;
    endcase
  end

  always_comb begin
    state_next = state;
    push = 1'b0;
    unique case (state)
      F_IDLE: begin
        if (take) begin
          state_next = (skip_in || in_word.func == FN_FIND) ? F_PUSH : F_MUL;
        end
      end
      F_MUL: state_next = F_SUM;
      F_SUM: begin
        if (round) begin
          state_next = POW2 ? F_PUSH : F_REM;
        end else begin
          state_next = F_MUL;
        end
      end
      F_REM: begin
        if (step == 3'd7) state_next = F_RED;
      end
      F_RED: begin
        if (step == 3'd0) state_next = F_PUSH;
      end
      F_PUSH: begin
        push = 1'b1;
        if (!q_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        if (take) begin
          job   <= '{func: in_word.func, skip: skip_in, ino: in_word.ino,
                     value: in_word.path_value};
          x     <= in_word.ino ^ (in_word.ino >> MIX_SHIFT);
          round <= 1'b0;
          acc   <= '0;
          step  <= 3'd0;
        end
      end
      F_MUL: begin
        p_ll <= {32'b0, x[31:0]} * {32'b0, mul_c[31:0]};
        p_lh <= 32'(x[31:0] * mul_c[63:32]);
        p_hl <= 32'(x[63:32] * mul_c[31:0]);
      end
      F_SUM: begin
        x     <= y ^ (y >> MIX_SHIFT);
        round <= 1'b1;
      end
      F_REM: begin
        // Advance one byte; after the last, start trimming at 32 * CAPACITY.
        acc  <= acc + part;
        x    <= x >> 8;
        step <= (step == 3'd7) ? 3'd5 : step + 3'd1;
      end
      F_RED: begin
        acc  <= acc_red;
        step <= step - 3'd1;
      end
      default: ;
    endcase
  end

  assign busy      = state != F_IDLE;
  assign push_data = {home, job};

endmodule

`default_nettype wire

### hw/rtl/lpim_queue.sv
`default_nettype none

module lpim_queue import lpim_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  output logic                  q_valid,
  output logic [WIDTH-1:0]      q_data,
  input  wire logic             pop
);

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  logic [WIDTH-1:0] ent [QDEPTH];
  logic [AW-1:0]    wp, rp;
  logic [AW:0]      count;
  logic             do_push, do_pop;

  assign full    = count == (AW+1)'(QDEPTH);
  assign q_valid = count != '0;
  assign q_data  = ent[rp];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) wp <= (wp == AW'(QDEPTH - 1)) ? '0 : wp + 1'b1;
      if (do_pop)  rp <= (rp == AW'(QDEPTH - 1)) ? '0 : rp + 1'b1;
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent[wp] <= push_data;
  end

endmodule

`default_nettype wire

### hw/rtl/lpim_back.sv
`default_nettype none

module lpim_back import lpim_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      q_valid,
  input  wire logic [IW+$bits(job_t)-1:0] q_data,
  output logic                           pop,
  output logic                           clearing,
  output logic                           out_valid,
  output out_word_t                      out_word,
  input  wire logic                      out_stall
);

  localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);

  entry_t mem [CAPACITY];
  entry_t rd_q;

  back_state_t state, state_next;
  job_t        job, q_job;
  logic [IW-1:0] q_home;
  logic [IW-1:0] idx, idx_next, cnt, cnt_next;
  out_word_t   res, res_next;
  logic        load_out;
  logic        wr_en;
  entry_t      wr_data;

  assign q_job  = job_t'(q_data[$bits(job_t)-1:0]);
  assign q_home = q_data[IW+$bits(job_t)-1:$bits(job_t)];
  assign clearing = state == B_CLR;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cnt_next   = cnt;
    res_next   = res;
    pop        = 1'b0;
    load_out   = 1'b0;
    wr_en      = 1'b0;
    wr_data    = '0;
    unique case (state)
      B_CLR: begin
        wr_en = 1'b1;
        if (idx == LAST) begin
          idx_next   = '0;
          state_next = B_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      B_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          res_next   = '0;
          cnt_next   = '0;
          idx_next   = (q_job.func == FN_FIND) ? '0 : q_home;
          state_next = q_job.skip ? B_DONE : B_RD;
        end
      end
      B_RD: state_next = B_CHK;
      B_CHK: begin
        state_next = B_DONE;
        if (job.func == FN_FIND) begin
          if (rd_q.used && (rd_q.rpath == job.value || rd_q.dpath == job.value)) begin
            res_next.found   = 1'b1;
            res_next.ino_out = rd_q.key;
          end else if (cnt != LAST) begin
            state_next = B_RD;
          end
        end else if (!rd_q.used) begin
          if (job.func == FN_PUT) begin
            wr_en          = 1'b1;
            wr_data        = '{used: 1'b1, key: job.ino, rpath: job.value, dpath: 32'd0};
            res_next.found = 1'b1;
          end
        end else if (rd_q.key == job.ino) begin
          res_next.found = 1'b1;
          wr_data        = rd_q;
          unique case (job.func)
            FN_PUT: begin
              wr_en         = 1'b1;
              wr_data.rpath = job.value;
            end
            FN_REDIR: begin
              wr_en         = 1'b1;
              wr_data.dpath = job.value;
            end
            default: begin
              res_next.path_out = (rd_q.dpath != 32'd0) ? rd_q.dpath : rd_q.rpath;
            end
          endcase
        end else if (cnt != LAST) begin
          state_next = B_RD;
        end
        if (state_next == B_RD) begin
          cnt_next = cnt + 1'b1;
          idx_next = (idx == LAST) ? '0 : idx + 1'b1;
        end
      end
      B_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLR;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt_next;
    res <= res_next;
    if (pop) job <= q_job;
    if (load_out) out_word <= res;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[idx] <= wr_data;
    rd_q <= mem[idx];
  end

`include "linear_probe_inode_map_macros.svh"

  `LPIM_ASSERT_NOW(a_write_state, wr_en, (state == B_CLR || state == B_CHK), "write outside clear or check")
  `LPIM_ASSERT_NOW(a_no_pop_clear, clearing, !pop, "item taken during clearing pass")
  `LPIM_ASSERT_NEXT(a_skip_miss, (pop && q_job.skip), !res.found, "skipped item reported a hit")
  `LPIM_ASSERT_NOW(a_path_get, load_out, (res.path_out == 32'd0 || job.func == FN_GET), "path out on non-get")

endmodule

`default_nettype wire

### dv/linear_probe_inode_map_test.sv
`default_nettype none

module linear_probe_inode_map_test;
  import lpim_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = CAPACITY_DEF;
  localparam int IDLE_LIMIT = 20000;
  localparam int DIRECTED_ROWS = 22;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  always #2 clk = ~clk;

  linear_probe_inode_map DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  // Private copy of the table, updated in acceptance order.
  logic        map_used [SLOTS];
  logic [63:0] map_key  [SLOTS];
  logic [31:0] map_real [SLOTS];
  logic [31:0] map_redir[SLOTS];

  out_word_t pending_words[$];
  int        mismatches = 0;
  int        words_sent = 0;
  int        words_seen = 0;
  int        idle_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hits_seen = 0;

  // Known keys so random traffic hits existing entries.
  logic [63:0] known_keys[$];
  logic [31:0] known_paths[$];

  function automatic int slot_of(logic [63:0] k);
    logic [63:0] x;
    x = k;
    x = x ^ (x >> MIX_SHIFT);
    x = x * MIX_C1;
    x = x ^ (x >> MIX_SHIFT);
    x = x * MIX_C2;
    x = x ^ (x >> MIX_SHIFT);
    return int'(x % SLOTS);
  endfunction

  // Walk the probe chain; return slot holding key or -1, and first free slot.
  function automatic int locate_key(logic [63:0] k, output int free_slot);
    int idx;
    idx = slot_of(k);
    free_slot = -1;
    for (int n = 0; n < SLOTS; n++) begin
      if (!map_used[idx]) begin
        free_slot = idx;
        return -1;
      end
      if (map_key[idx] == k) return idx;
      idx = (idx + 1) % SLOTS;
    end
    return -1;
  endfunction

  // Apply one word to the table copy and compute its result word.
  function automatic out_word_t apply_map_op(in_word_t w);
    out_word_t r;
    int hit;
    int fre;
    r = '0;
    case (w.func)
      FN_PUT: if (w.ino != 0 && w.path_present) begin
        hit = locate_key(w.ino, fre);
        if (hit >= 0) begin
          map_real[hit] = w.path_value;
          r.found = 1'b1;
        end else if (fre >= 0) begin
          map_used[fre] = 1'b1;
          map_key[fre] = w.ino;
          map_real[fre] = w.path_value;
          map_redir[fre] = '0;
          r.found = 1'b1;
        end
      end
      FN_REDIR: if (w.ino != 0 && w.path_present) begin
        hit = locate_key(w.ino, fre);
        if (hit >= 0) begin
          map_redir[hit] = w.path_value;
          r.found = 1'b1;
        end
      end
      FN_GET: if (w.ino != 0) begin
        hit = locate_key(w.ino, fre);
        if (hit >= 0) begin
          r.path_out = (map_redir[hit] != 0) ? map_redir[hit] : map_real[hit];
          r.found = 1'b1;
        end
      end
      default: if (w.path_present) begin
        // Scan from slot zero; first used match wins.
        for (int i = 0; i < SLOTS; i++) begin
          if (map_used[i] && (map_real[i] == w.path_value || map_redir[i] == w.path_value)) begin
            r.ino_out = map_key[i];
            r.found = 1'b1;
            break;
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("ERROR: %s got %h expected %h (result %0d)", what, got, want, words_seen);
  endtask

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver: check accepted words, then pick next stall level.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        words_seen++;
        if (pending_words.size() == 0) begin
          report_mismatch("unexpected word", out_word.ino_out, '0);
        end else begin
          want = pending_words.pop_front();
          if (want.found) hits_seen++;
          if (out_word.found !== want.found)
            report_mismatch("found", 64'(out_word.found), 64'(want.found));
          if (out_word.path_out !== want.path_out)
            report_mismatch("path_out", 64'(out_word.path_out), 64'(want.path_out));
          if (out_word.ino_out !== want.ino_out)
            report_mismatch("ino_out", out_word.ino_out, want.ino_out);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Present one word and hold it until accepted; expectation is made at acceptance.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_words.push_back(apply_map_op(w));
    words_sent++;
    if (w.func == FN_PUT && w.ino != 0 && w.path_present) begin
      known_keys.push_back(w.ino);
      known_paths.push_back(w.path_value);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  function automatic in_word_t make_word(func_t f, logic [63:0] k, logic p, logic [31:0] v);
    in_word_t w;
    w.func = f;
    w.ino = k;
    w.path_present = p;
    w.path_value = v;
    return w;
  endfunction

  // Mostly well-formed traffic against known keys, with some noise.
  function automatic in_word_t random_word();
    in_word_t w;
    int sel;
    w.func = func_t'($urandom_range(3));
    sel = $urandom_range(99);
    if (known_keys.size() != 0 && sel < 60)
      w.ino = known_keys[$urandom_range(known_keys.size() - 1)];
    else if (sel < 63)
      w.ino = '0;
    else
      w.ino = {$urandom, $urandom};
    w.path_present = ($urandom_range(9) != 0);
    sel = $urandom_range(99);
    if (known_paths.size() != 0 && sel < 50)
      w.path_value = known_paths[$urandom_range(known_paths.size() - 1)];
    else if (sel < 60)
      w.path_value = '0;
    else
      w.path_value = $urandom;
    return w;
  endfunction

  // Directed rows: word plus hand-written expectation where obvious.
  in_word_t  dir_word[DIRECTED_ROWS];
  logic      dir_typed[DIRECTED_ROWS];
  out_word_t dir_want[DIRECTED_ROWS];

  initial begin
    out_word_t hand;
    int row;
    for (int i = 0; i < SLOTS; i++) begin
      map_used[i] = 1'b0;
      map_key[i] = '0;
      map_real[i] = '0;
      map_redir[i] = '0;
    end
    row = 0;
    // Empty table: every lookup misses.
    dir_word[row] = make_word(FN_GET, 64'h1, 1'b1, 32'h0); dir_typed[row] = 1'b1;
    dir_want[row] = '0; row++;
    dir_word[row] = make_word(FN_FIND, 64'h0, 1'b1, 32'h0); dir_typed[row] = 1'b1;
    dir_want[row] = '0; row++;
    // Zero key and absent path are ignored; a redirect of an absent key misses.
    dir_word[row] = make_word(FN_PUT, 64'h0, 1'b1, 32'h5); dir_typed[row] = 1'b1;
    dir_want[row] = '0; row++;
    dir_word[row] = make_word(FN_PUT, 64'h7, 1'b0, 32'h5); dir_typed[row] = 1'b1;
    dir_want[row] = '0; row++;
    dir_word[row] = make_word(FN_REDIR, 64'h7, 1'b1, 32'h9); dir_typed[row] = 1'b1;
    dir_want[row] = '0; row++;
    // Extremes of key and handle.
    dir_word[row] = make_word(FN_PUT, '1, 1'b1, '1); dir_typed[row] = 1'b1;
    dir_want[row] = '0; dir_want[row].found = 1'b1; row++;
    dir_word[row] = make_word(FN_GET, '1, 1'b0, 32'h0); dir_typed[row] = 1'b1;
    dir_want[row] = '0; dir_want[row].found = 1'b1; dir_want[row].path_out = '1; row++;
    dir_word[row] = make_word(FN_PUT, 64'h1, 1'b1, 32'h0); dir_typed[row] = 1'b0; row++;
    dir_word[row] = make_word(FN_PUT, 64'h8000_0000_0000_0000, 1'b1, 32'h8000_0000);
    dir_typed[row] = 1'b0; row++;
    // Update real path, then redirect overrides it on get.
    dir_word[row] = make_word(FN_PUT, '1, 1'b1, 32'h1234); dir_typed[row] = 1'b0; row++;
    dir_word[row] = make_word(FN_REDIR, '1, 1'b1, 32'hABCD); dir_typed[row] = 1'b0; row++;
    dir_word[row] = make_word(FN_GET, '1, 1'b1, 32'h0); dir_typed[row] = 1'b0; row++;
    dir_word[row] = make_word(FN_PUT, '1, 1'b1, 32'h5555); dir_typed[row] = 1'b0; row++;
    dir_word[row] = make_word(FN_GET, '1, 1'b0, 32'h0); dir_typed[row] = 1'b0; row++;
    // Find by real, by redirect, by empty path, with absent path, and a miss.
    dir_word[row] = make_word(FN_FIND, '0, 1'b1, 32'h5555); dir_typed[row] = 1'b0; row++;
    dir_word[row] = make_word(FN_FIND, '1, 1'b1, 32'hABCD); dir_typed[row] = 1'b0; row++;
    dir_word[row] = make_word(FN_FIND, '0, 1'b1, 32'h0); dir_typed[row] = 1'b0; row++;
    dir_word[row] = make_word(FN_FIND, '0, 1'b0, 32'h5555); dir_typed[row] = 1'b1;
    dir_want[row] = '0; row++;
    dir_word[row] = make_word(FN_FIND, '0, 1'b1, 32'hDEAD_BEEF); dir_typed[row] = 1'b0;
    row++;
    // Clear redirect back to empty; get falls back to real path; a zero-key get misses.
    dir_word[row] = make_word(FN_REDIR, '1, 1'b1, 32'h0); dir_typed[row] = 1'b0; row++;
    dir_word[row] = make_word(FN_GET, '1, 1'b1, 32'h0); dir_typed[row] = 1'b0; row++;
    dir_word[row] = make_word(FN_GET, 64'h0, 1'b1, 32'h0); dir_typed[row] = 1'b1;
    dir_want[row] = '0; row++;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table, no idling.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_word(dir_word[i]);
      if (dir_typed[i]) begin
        hand = pending_words[$];
        if (hand !== dir_want[i])
          report_mismatch("directed row table", 64'(hand), 64'(dir_want[i]));
        pending_words[$] = dir_want[i];
      end
    end
    // Let every result land before traffic resumes.
    drain_results();

    // Random phases, each with its own idle mix.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      for (int n = 0; n < 330; n++) send_word(random_word());
      drain_results();
    end

    // Fill the table to capacity so a put gets dropped.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int n = 0; n < SLOTS + 8; n++)
      send_word(make_word(FN_PUT, {$urandom, $urandom} | 64'h1, 1'b1, $urandom));
    for (int n = 0; n < 16; n++) send_word(random_word());

    drain_results();
    repeat (2 * SLOTS + 20) @(posedge clk);

    $display("Ran %0d words (directed, four idle mixes, full table); %0d hit results.",
             words_sent, hits_seen);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
+incdir+hw/rtl
hw/rtl/lpim_pkg.sv
hw/rtl/lpim_front.sv
hw/rtl/lpim_queue.sv
hw/rtl/lpim_back.sv
hw/rtl/linear_probe_inode_map.sv
dv/linear_probe_inode_map_test.sv
